/* hw/rtl/rhid_pkg.sv */
// Shared types, constants and helpers for the Rossler Heun integrator.
// Fixed-point format, register and selector codes, saturation functions.
// No dependencies.
package rhid_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int DT_W      = 25;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SEL_W     = 3;
    localparam int DLY_W     = 8;

    // shared multiplier: 33 bits holds a sum of two values and a zero-extended dt
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ACC_W  = 2 * DATA_W - FRAC_BITS + 2;

    typedef logic signed [DATA_W-1:0] t_val;

    localparam t_val VAL_MAX = 32'sh7fff_ffff;
    localparam t_val VAL_MIN = 32'sh8000_0000;
    localparam t_val ONE     = (FRAC_BITS >= DATA_W - 1) ? VAL_MAX
                                                         : t_val'(64'd1 << FRAC_BITS);

    localparam t_val             COEF_A_RST    = 32'sd3355443;
    localparam t_val             COEF_B_RST    = 32'sd3355443;
    localparam t_val             COEF_C_RST    = 32'sd95630131;
    localparam logic [DT_W-1:0]  TIME_STEP_RST = 25'd335544;
    localparam logic [DLY_W-1:0] DELAY_RST     = 8'd20;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A,
        REG_COEF_B,
        REG_COEF_C,
        REG_TIME_STEP,
        REG_DELAY,
        REG_X_SEL,
        REG_Y_SEL
    } t_reg_idx;

    typedef enum logic [SEL_W-1:0] {
        SEL_X_NOW,
        SEL_Y_NOW,
        SEL_Z_NOW,
        SEL_X_DLY,
        SEL_Y_DLY,
        SEL_Z_DLY
    } t_plot_sel;

    typedef struct packed {
        t_val x;
        t_val y;
        t_val z;
    } t_vec3;

    typedef struct packed {
        t_val            a;
        t_val            b;
        t_val            c;
        logic [DT_W-1:0] dt;
    } t_coefs;

    typedef struct packed {
        logic done;
        logic sat;
    } t_heun_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FIN
    } t_ctl_state;

    // one phase per multiply issued to the shared multiplier, then a drain phase
    typedef enum logic [3:0] {
        PH_MUL_AY,
        PH_MUL_XZ,
        PH_MUL_CZ,
        PH_MUL_DTKX,
        PH_MUL_DTKY,
        PH_MUL_DTKZ,
        PH_MUL_APY,
        PH_MUL_PXPZ,
        PH_MUL_CPZ,
        PH_MUL_DTSX,
        PH_MUL_DTSY,
        PH_MUL_DTSZ,
        PH_DRAIN
    } t_heun_phase;

    function automatic t_val sat_val(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(VAL_MAX)) begin
            return VAL_MAX;
        end else if (v < SUM_W'(VAL_MIN)) begin
            return VAL_MIN;
        end
        return t_val'(v);
    endfunction

    function automatic logic is_clamped(input logic signed [SUM_W-1:0] v);
        return (v > SUM_W'(VAL_MAX)) || (v < SUM_W'(VAL_MIN));
    endfunction

endpackage

/* hw/rtl/rossler_heun_integrator_delay_core.sv */
// Top level of the Rossler Heun integrator with delayed plot coordinates.
// Depends on rhid_pkg, rhid_heun and rhid_ram.
//
// Integrates the Rossler system in Q8.24 with one Heun step per step item and
// returns the new state plus two plot coordinates, each the current or the
// delayed x, y or z. The block works on one item at a time: a step item
// occupies it from its transfer until the next item can be taken, through
// the twelve multiplies issued one per cycle to the single shared 33x33
// multiplier and the finish state; a load item goes straight to finish. The
// result sits in an output register, so the next item is taken while a result
// waits. History is kept in one RAM of MAX_DELAY+1 entries holding x, y and z;
// the delayed entry is read once per step and the new state written back at the
// end, with the new state forwarded when the delay is zero. Entries are never
// cleared: a delayed coordinate reads as zero until delay+1 steps follow a load.
module rossler_heun_integrator_delay_core import rhid_pkg::*; #(
    parameter int MAX_DELAY = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic signed [31:0]   i_init_x,
    input  logic signed [31:0]   i_init_y,
    input  logic signed [31:0]   i_init_z,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_state_x,
    output logic signed [31:0]   o_state_y,
    output logic signed [31:0]   o_state_z,
    output logic signed [31:0]   o_plot_x,
    output logic signed [31:0]   o_plot_y,
    output logic                 o_history_valid,
    output logic                 o_saturated
);

    localparam int RING_LEN = MAX_DELAY + 1;
    localparam int AW       = $clog2(RING_LEN);
    localparam int FW       = $clog2(RING_LEN + 1);
    localparam int GW       = (FW > DLY_W) ? FW : DLY_W;

    // configuration
    t_val             r_coef_a;
    t_val             r_coef_b;
    t_val             r_coef_c;
    logic [DT_W-1:0]  r_time_step;
    logic [DLY_W-1:0] r_delay;
    logic [SEL_W-1:0] r_x_sel;
    logic [SEL_W-1:0] r_y_sel;

    // control and state
    t_ctl_state       r_st;
    t_ctl_state       n_st;
    logic             r_req;
    t_vec3            r_init;
    t_vec3            r_cur;
    logic [AW-1:0]    r_widx;
    logic [FW-1:0]    r_fill;

    // output register
    logic             r_out_valid;
    t_vec3            r_out_state;
    t_val             r_out_plot_x;
    t_val             r_out_plot_y;
    logic             r_out_hist;
    logic             r_out_sat;

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic             w_out_free;
    logic             w_commit;
    logic             w_is_step;
    t_coefs           w_coefs;
    t_vec3            w_heun_next;
    t_heun_stat       w_heun_stat;
    logic [GW-1:0]    w_dly_ext;
    logic [GW-1:0]    w_eff;
    logic [GW-1:0]    w_widx_ext;
    logic [AW-1:0]    w_didx;
    t_vec3            w_new;
    t_vec3            w_dly;
    logic [3*DATA_W-1:0] w_rdata;
    logic [AW-1:0]    n_widx;
    logic [FW-1:0]    n_fill;
    logic             w_hist;

    function automatic t_val pick(input logic [SEL_W-1:0] sel, input logic vld,
                                  input t_vec3 now, input t_vec3 dly);
        case (sel)
            SEL_X_NOW: return now.x;
            SEL_Y_NOW: return now.y;
            SEL_Z_NOW: return now.z;
            SEL_X_DLY: return vld ? dly.x : '0;
            SEL_Y_DLY: return vld ? dly.y : '0;
            SEL_Z_DLY: return vld ? dly.z : '0;
            default:   return '0;
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a    <= COEF_A_RST;
            r_coef_b    <= COEF_B_RST;
            r_coef_c    <= COEF_C_RST;
            r_time_step <= TIME_STEP_RST;
            r_delay     <= DELAY_RST;
            r_x_sel     <= SEL_X_NOW;
            r_y_sel     <= SEL_Y_NOW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COEF_A:    r_coef_a    <= t_val'(i_cfg_data);
                REG_COEF_B:    r_coef_b    <= t_val'(i_cfg_data);
                REG_COEF_C:    r_coef_c    <= t_val'(i_cfg_data);
                REG_TIME_STEP: r_time_step <= i_cfg_data[DT_W-1:0];
                REG_DELAY:     r_delay     <= i_cfg_data[DLY_W-1:0];
                REG_X_SEL:     r_x_sel     <= i_cfg_data[SEL_W-1:0];
                REG_Y_SEL:     r_y_sel     <= i_cfg_data[SEL_W-1:0];
                default:       r_delay     <= r_delay;
            endcase
        end
    end

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_is_step  = (r_req == REQ_STEP);

    assign w_coefs = '{a: r_coef_a, b: r_coef_b, c: r_coef_c, dt: r_time_step};

    rhid_heun u_heun (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_xfer && (i_req_type == REQ_STEP)),
        .i_state (r_cur),
        .i_coef  (w_coefs),
        .o_next  (w_heun_next),
        .o_stat  (w_heun_stat)
    );

    // delay clamps to MAX_DELAY; delayed index wraps around the ring
    assign w_dly_ext  = GW'(r_delay);
    assign w_eff      = (w_dly_ext > GW'(MAX_DELAY)) ? GW'(MAX_DELAY) : w_dly_ext;
    assign w_widx_ext = GW'(r_widx);
    assign w_didx     = (w_widx_ext >= w_eff) ? AW'(w_widx_ext - w_eff)
                                              : AW'(w_widx_ext + GW'(RING_LEN) - w_eff);

    rhid_ram #(
        .WIDTH (3 * DATA_W),
        .DEPTH (RING_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_commit && w_is_step),
        .i_waddr (r_widx),
        .i_wdata (w_new),
        .i_re    (w_in_xfer && (i_req_type == REQ_STEP)),
        .i_raddr (w_didx),
        .o_rdata (w_rdata)
    );

    assign w_new = w_is_step ? w_heun_next : r_init;
    // zero delay reads the entry being written now: forward it
    assign w_dly = (w_eff == '0) ? w_new : t_vec3'(w_rdata);

    always_comb begin
        if (w_is_step) begin
            n_widx = (r_widx == AW'(RING_LEN - 1)) ? '0 : r_widx + 1'b1;
            n_fill = (r_fill < FW'(RING_LEN)) ? r_fill + 1'b1 : r_fill;
        end else begin
            n_widx = '0;
            n_fill = '0;
        end
    end

    assign w_hist = GW'(n_fill) > w_eff;

    always_comb begin
        n_st     = r_st;
        w_commit = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_st = (i_req_type == REQ_STEP) ? ST_CALC : ST_FIN;
                end
            end
            ST_CALC: begin
                if (w_heun_stat.done) begin
                    n_st = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_st     = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_cur       <= '{x: ONE, y: ONE, z: ONE};
            r_widx      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_commit) begin
                r_cur       <= w_new;
                r_widx      <= n_widx;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req  <= i_req_type;
            r_init <= '{x: i_init_x, y: i_init_y, z: i_init_z};
        end
        if (w_commit) begin
            r_out_state  <= w_new;
            r_out_plot_x <= pick(r_x_sel, w_hist, w_new, w_dly);
            r_out_plot_y <= pick(r_y_sel, w_hist, w_new, w_dly);
            r_out_hist   <= w_hist;
            r_out_sat    <= w_is_step && w_heun_stat.sat;
        end
    end

    assign o_in_stall      = (r_st != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_state_x       = r_out_state.x;
    assign o_state_y       = r_out_state.y;
    assign o_state_z       = r_out_state.z;
    assign o_plot_x        = r_out_plot_x;
    assign o_plot_y        = r_out_plot_y;
    assign o_history_valid = r_out_hist;
    assign o_saturated     = r_out_sat;

endmodule

/* hw/rtl/rhid_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Holds the delay history; no dependencies.
module rhid_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rhid_heun.sv */
// Heun step engine: twelve multiplies through one shared registered multiplier,
// with a rounding, accumulate and saturate stage behind it. Uses rhid_pkg.
module rhid_heun import rhid_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_vec3      i_state,
    input  t_coefs     i_coef,
    output t_vec3      o_next,
    output t_heun_stat o_stat
);

    localparam logic signed [PROD_W-1:0] HALF_A = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] HALF_B = PROD_W'(1) << FRAC_BITS;

    logic        r_busy;
    logic        r_done;
    t_heun_phase r_ph;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_sat;
    t_vec3                    r_k1;
    t_vec3                    r_p;
    t_vec3                    r_k2;
    t_vec3                    r_n;

    logic signed [MUL_W-1:0]  w_opa;
    logic signed [MUL_W-1:0]  w_opb;
    logic signed [MUL_W-1:0]  w_dt;
    logic signed [PROD_W-1:0] w_rnd_a;
    logic signed [PROD_W-1:0] w_rnd_b;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [ACC_W-1:0]  w_addend;
    logic                     w_sub;
    logic                     w_half;
    logic signed [SUM_W-1:0]  w_rnd_ext;
    logic signed [SUM_W-1:0]  w_sum;
    t_val                     w_sum_sat;
    t_val                     w_neg_a;
    t_val                     w_neg_b;
    logic signed [SUM_W-1:0]  w_neg;
    t_val                     w_neg_sat;
    logic                     w_chk_sum;
    logic                     w_chk_neg;
    logic                     w_sat_now;

    assign w_dt = MUL_W'($signed({1'b0, i_coef.dt}));

    // operand select for the multiply issued in this phase
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (r_ph)
            PH_MUL_AY:   begin w_opa = MUL_W'(i_coef.a);  w_opb = MUL_W'(i_state.y); end
            PH_MUL_XZ:   begin w_opa = MUL_W'(i_state.x); w_opb = MUL_W'(i_state.z); end
            PH_MUL_CZ:   begin w_opa = MUL_W'(i_coef.c);  w_opb = MUL_W'(i_state.z); end
            PH_MUL_DTKX: begin w_opa = w_dt;              w_opb = MUL_W'(r_k1.x);    end
            PH_MUL_DTKY: begin w_opa = w_dt;              w_opb = MUL_W'(r_k1.y);    end
            PH_MUL_DTKZ: begin w_opa = w_dt;              w_opb = MUL_W'(r_k1.z);    end
            PH_MUL_APY:  begin w_opa = MUL_W'(i_coef.a);  w_opb = MUL_W'(r_p.y);     end
            PH_MUL_PXPZ: begin w_opa = MUL_W'(r_p.x);     w_opb = MUL_W'(r_p.z);     end
            PH_MUL_CPZ:  begin w_opa = MUL_W'(i_coef.c);  w_opb = MUL_W'(r_p.z);     end
            PH_MUL_DTSX: begin
                w_opa = w_dt;
                w_opb = MUL_W'(r_k1.x) + MUL_W'(r_k2.x);
            end
            PH_MUL_DTSY: begin
                w_opa = w_dt;
                w_opb = MUL_W'(r_k1.y) + MUL_W'(r_k2.y);
            end
            PH_MUL_DTSZ: begin
                w_opa = w_dt;
                w_opb = MUL_W'(r_k1.z) + MUL_W'(r_k2.z);
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // round to nearest, ties up; the final update folds the half into the shift
    assign w_rnd_a = (r_prod + HALF_A) >>> FRAC_BITS;
    assign w_rnd_b = (r_prod + HALF_B) >>> (FRAC_BITS + 1);

    // post stage works on the product issued in the previous phase
    always_comb begin
        w_addend  = '0;
        w_sub     = 1'b0;
        w_half    = 1'b0;
        w_chk_sum = 1'b0;
        w_chk_neg = 1'b0;
        w_neg_a   = r_p.y;
        w_neg_b   = r_p.z;
        case (r_ph)
            PH_MUL_AY: begin
                w_neg_a   = i_state.y;
                w_neg_b   = i_state.z;
                w_chk_neg = 1'b1;
            end
            PH_MUL_XZ:   begin w_addend = ACC_W'(i_state.x); w_chk_sum = 1'b1; end
            PH_MUL_CZ:   begin w_addend = ACC_W'(i_coef.b); end
            PH_MUL_DTKX: begin w_addend = r_acc; w_sub = 1'b1; w_chk_sum = 1'b1; end
            PH_MUL_DTKY: begin w_addend = ACC_W'(i_state.x); w_chk_sum = 1'b1; end
            PH_MUL_DTKZ: begin w_addend = ACC_W'(i_state.y); w_chk_sum = 1'b1; end
            PH_MUL_APY:  begin w_addend = ACC_W'(i_state.z); w_chk_sum = 1'b1; end
            PH_MUL_PXPZ: begin
                w_addend  = ACC_W'(r_p.x);
                w_chk_sum = 1'b1;
                w_chk_neg = 1'b1;
            end
            PH_MUL_CPZ:  begin w_addend = ACC_W'(i_coef.b); end
            PH_MUL_DTSX: begin w_addend = r_acc; w_sub = 1'b1; w_chk_sum = 1'b1; end
            PH_MUL_DTSY: begin
                w_addend  = ACC_W'(i_state.x);
                w_half    = 1'b1;
                w_chk_sum = 1'b1;
            end
            PH_MUL_DTSZ: begin
                w_addend  = ACC_W'(i_state.y);
                w_half    = 1'b1;
                w_chk_sum = 1'b1;
            end
            PH_DRAIN: begin
                w_addend  = ACC_W'(i_state.z);
                w_half    = 1'b1;
                w_chk_sum = 1'b1;
            end
            default: begin
                w_addend = '0;
            end
        endcase
    end

    assign w_rnd     = w_half ? w_rnd_b : w_rnd_a;
    assign w_rnd_ext = SUM_W'(w_rnd);
    assign w_sum     = SUM_W'(w_addend) + (w_sub ? -w_rnd_ext : w_rnd_ext);
    assign w_sum_sat = sat_val(w_sum);
    assign w_neg     = -SUM_W'(w_neg_a) - SUM_W'(w_neg_b);
    assign w_neg_sat = sat_val(w_neg);
    assign w_sat_now = (w_chk_sum && is_clamped(w_sum)) || (w_chk_neg && is_clamped(w_neg));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= PH_MUL_AY;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_ph == PH_DRAIN) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_ph   <= PH_MUL_AY;
                end else begin
                    r_ph <= t_heun_phase'(r_ph + 4'd1);
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= PH_MUL_AY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_prod <= w_opa * w_opb;
            r_sat  <= r_sat | w_sat_now;
            case (r_ph)
                PH_MUL_AY:   r_k1.x <= w_neg_sat;
                PH_MUL_XZ:   r_k1.y <= w_sum_sat;
                PH_MUL_CZ:   r_acc  <= ACC_W'(w_sum);
                PH_MUL_DTKX: r_k1.z <= w_sum_sat;
                PH_MUL_DTKY: r_p.x  <= w_sum_sat;
                PH_MUL_DTKZ: r_p.y  <= w_sum_sat;
                PH_MUL_APY:  r_p.z  <= w_sum_sat;
                PH_MUL_PXPZ: begin
                    r_k2.y <= w_sum_sat;
                    r_k2.x <= w_neg_sat;
                end
                PH_MUL_CPZ:  r_acc  <= ACC_W'(w_sum);
                PH_MUL_DTSX: r_k2.z <= w_sum_sat;
                PH_MUL_DTSY: r_n.x  <= w_sum_sat;
                PH_MUL_DTSZ: r_n.y  <= w_sum_sat;
                PH_DRAIN:    r_n.z  <= w_sum_sat;
                default:     r_acc  <= r_acc;
            endcase
        end
    end

    assign o_next = r_n;
    assign o_stat = '{done: r_done, sat: r_sat};

endmodule

/* hw/rtl/rhid_checker.sv */
// Port-level checker for the Rossler Heun integrator, bound to the top level.
// Depends on rhid_pkg for register and selector codes.
module rhid_checker import rhid_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic signed [31:0]   o_state_x,
    input logic signed [31:0]   o_state_y,
    input logic signed [31:0]   o_state_z,
    input logic signed [31:0]   o_plot_x,
    input logic signed [31:0]   o_plot_y,
    input logic                 o_history_valid,
    input logic                 o_saturated
);

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic [2:0]       r_pend;
    logic [SEL_W-1:0] r_x_sel;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = o_out_valid && !i_out_stall;

    // count items taken whose result has not been transferred yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_xfer && !w_out_xfer) begin
            r_pend <= r_pend + 1'b1;
        end else if (!w_in_xfer && w_out_xfer && (r_pend != '0)) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    // shadow the plot_x selector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_sel <= SEL_X_NOW;
        end else if (i_cfg_we && (i_cfg_index == REG_X_SEL)) begin
            r_x_sel <= i_cfg_data[SEL_W-1:0];
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("input taken while an item is in work");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != '0))
        else $error("result shown without an item taken");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd2)
        else $error("more than two items outstanding");

    a_plot_now_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_x_sel == SEL_X_NOW)) |-> (o_plot_x == o_state_x))
        else $error("plot_x differs from current x");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_state_x) && $stable(o_state_y)
             && $stable(o_state_z) && $stable(o_plot_x) && $stable(o_plot_y)
             && $stable(o_history_valid) && $stable(o_saturated)))
        else $error("stalled result changed");

endmodule

bind rossler_heun_integrator_delay_core rhid_checker u_rhid_checker (.*);
